// ===== rtl/p2a_pkg.sv =====
// ----------------------------------------------------------------------------
// p2a_pkg
// shared types, constants and tables for the pixel to glyph and color block
// ----------------------------------------------------------------------------
package p2a_pkg;

    localparam int CHAN_W       = 8;
    localparam int YQ_W         = 22;
    localparam int HUE_W        = 17;
    localparam int DIST_W       = 17;
    localparam int GLYPH_W      = 7;
    localparam int COLOR_W      = 6;
    localparam int LEVEL_W      = 4;
    localparam int HUE_IDX_W    = 3;
    localparam int GLYPH_LEVELS = 11;
    localparam int HUE_ENTRIES  = 6;

    localparam longint Y_FULL_SCALE = 64'd2550000;
    localparam longint LSTAR_CUBE   = 64'd1560896;

    localparam logic [COLOR_W-1:0] COLOR_BLACK = 6'd30;
    localparam logic [COLOR_W-1:0] COLOR_RED   = 6'd31;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 6'd37;

    typedef logic [YQ_W-1:0]    yq_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [HUE_W-1:0]   hue_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef yq_t thresh_arr_t [GLYPH_LEVELS];
    typedef int  hue_deg_arr_t [HUE_ENTRIES];

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_chan_t;

    localparam hue_deg_arr_t HUE_DEG = '{0, 120, 60, 240, 300, 180};

    // luminance limit of each lightness level, yq <= limit selects the level
    function automatic thresh_arr_t glyph_thresholds();
        thresh_arr_t th;
        longint      t;
        th[0] = '0;
        for (int i = 1; i < GLYPH_LEVELS; i++) begin
            t     = 64'(10 * i + 16);
            th[i] = YQ_W'(Y_FULL_SCALE * t * t * t / LSTAR_CUBE);
        end
        return th;
    endfunction

    localparam thresh_arr_t GLYPH_THRESH = glyph_thresholds();

    function automatic logic [GLYPH_W-1:0] glyph_char(input level_t lvl);
        logic [GLYPH_W-1:0] ch;
        case (lvl)
            4'd0:    ch = 7'd32;
            4'd1:    ch = 7'd46;
            4'd2:    ch = 7'd44;
            4'd3:    ch = 7'd58;
            4'd4:    ch = 7'd59;
            4'd5:    ch = 7'd116;
            4'd6:    ch = 7'd120;
            4'd7:    ch = 7'd64;
            4'd8:    ch = 7'd35;
            4'd9:    ch = 7'd78;
            default: ch = 7'd77;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/p2a_hue_argmin.sv =====
// ----------------------------------------------------------------------------
// p2a_hue_argmin
// picks the nearest table hue from six distances, first entry wins a tie
// ----------------------------------------------------------------------------
module p2a_hue_argmin
    import p2a_pkg::*;
(
    input  dist_t                hue_dist [HUE_ENTRIES],
    output logic [HUE_IDX_W-1:0] best_idx
);

    dist_t best_dist;

    always_comb begin
        best_dist = hue_dist[0];
        best_idx  = '0;
        for (int k = 1; k < HUE_ENTRIES; k++) begin
            if (hue_dist[k] < best_dist) begin
                best_dist = hue_dist[k];
                best_idx  = HUE_IDX_W'(k);
            end
        end
    end

endmodule

// ===== rtl/pixel_to_ascii_glyph_and_color.sv =====
// ----------------------------------------------------------------------------
// pixel_to_ascii_glyph_and_color
// turns one rgb pixel into an ascii glyph and an ansi foreground color code
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one pixel per request, s_tdata = red, green, blue
//   from the lowest byte up. m_ channel gives one result per pixel,
//   m_tdata = glyph_code [6:0], color_code [12:7], zero filled to 16 bits.
//   results leave in the order the pixels came in.
// pipeline and throughput:
//   four register stages; a pixel passes from stage 1 through to stage 4,
//   whose register drives m_tvalid and m_tdata. one pixel per cycle is
//   sustained while m_tready stays high, set by the four stage pipeline (max/min and
//   luminance, hue and level, six hue distances, argmin and glyph lookup).
// reset:
//   aresetn low clears all stage valid bits; no results are pending after.
// stall:
//   when m_tready is low the last stage holds its result; earlier stages
//   keep filling empty slots, and s_tready drops once every stage is full.
// ----------------------------------------------------------------------------
module pixel_to_ascii_glyph_and_color
    import p2a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_level, green_level, blue_level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // glyph_code, color_code, zero pad
);

    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign adv4     = !v4_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: luminance, channel max and min, max channel and hue difference
    logic [CHAN_W-1:0] red_in, green_in, blue_in;
    yq_t               yq_next, yq_reg;
    logic [CHAN_W-1:0] hi_next, lo_next, hi_reg, lo_reg;
    max_chan_t         sel_next, sel_reg;
    logic signed [CHAN_W:0] diff_next, diff_reg;

    assign red_in   = s_tdata[7:0];
    assign green_in = s_tdata[15:8];
    assign blue_in  = s_tdata[23:16];

    always_comb begin
        yq_next = YQ_W'(red_in) * YQ_W'(2126) + YQ_W'(green_in) * YQ_W'(7152)
                + YQ_W'(blue_in) * YQ_W'(722);
        hi_next  = red_in;
        sel_next = MAX_RED;
        if (green_in > hi_next) begin
            hi_next  = green_in;
            sel_next = MAX_GREEN;
        end
        if (blue_in > hi_next) begin
            hi_next  = blue_in;
            sel_next = MAX_BLUE;
        end
        lo_next = red_in;
        if (green_in < lo_next) lo_next = green_in;
        if (blue_in < lo_next) lo_next = blue_in;
        unique case (sel_next)
            MAX_RED:   diff_next = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
            MAX_GREEN: diff_next = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
            default:   diff_next = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            yq_reg   <= yq_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            sel_reg  <= sel_next;
            diff_reg <= diff_next;
        end
    end

    // stage 2: scaled hue, chroma, special cases, lightness level
    logic [CHAN_W-1:0]  c_next, c2_reg;
    logic signed [19:0] hn_wide;
    logic signed [19:0] hoff;
    hue_t               hn2_reg;
    logic               black_next, white_next, grey_next;
    logic               black2_reg, white2_reg, grey2_reg;
    level_t             level_next, level2_reg;

    always_comb begin
        c_next     = hi_reg - lo_reg;
        black_next = (hi_reg == '0);
        white_next = (lo_reg == '1);
        grey_next  = (c_next == '0);
        unique case (sel_reg)
            MAX_RED:   hoff = diff_reg[CHAN_W] ? 20'sd360 : 20'sd0;
            MAX_GREEN: hoff = 20'sd120;
            default:   hoff = 20'sd240;
        endcase
        hn_wide = 20'(diff_reg) * 20'sd60 + hoff * $signed({12'd0, c_next});
        level_next = level_t'(GLYPH_LEVELS - 1);
        for (int i = GLYPH_LEVELS - 1; i >= 1; i--) begin
            if (yq_reg <= GLYPH_THRESH[i]) level_next = level_t'(i);
        end
        if (yq_reg == '0) level_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            c2_reg     <= c_next;
            hn2_reg    <= hn_wide[HUE_W-1:0];
            black2_reg <= black_next;
            white2_reg <= white_next;
            grey2_reg  <= grey_next;
            level2_reg <= level_next;
        end
    end

    // stage 3: distance to each table hue
    dist_t  dist_next [HUE_ENTRIES];
    dist_t  dist3_reg [HUE_ENTRIES];
    logic   black3_reg, white3_reg, grey3_reg;
    level_t level3_reg;

    always_comb begin
        logic signed [HUE_W+1:0] d;
        for (int k = 0; k < HUE_ENTRIES; k++) begin
            d = $signed({2'b00, hn2_reg})
              - $signed({2'b00, HUE_W'(HUE_DEG[k]) * HUE_W'(c2_reg)});
            dist_next[k] = d[HUE_W+1] ? DIST_W'(-d) : DIST_W'(d);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            dist3_reg  <= dist_next;
            black3_reg <= black2_reg;
            white3_reg <= white2_reg;
            grey3_reg  <= grey2_reg;
            level3_reg <= level2_reg;
        end
    end

    // stage 4: nearest hue and glyph lookup, this is the output register
    logic [HUE_IDX_W-1:0] best_idx;
    logic [COLOR_W-1:0]   color_next, color4_reg;
    logic [GLYPH_W-1:0]   glyph4_reg;

    p2a_hue_argmin u_argmin (
        .hue_dist (dist3_reg),
        .best_idx (best_idx)
    );

    always_comb begin
        if (black3_reg) begin
            color_next = COLOR_BLACK;
        end else if (white3_reg) begin
            color_next = COLOR_WHITE;
        end else if (grey3_reg) begin
            color_next = COLOR_RED;
        end else begin
            color_next = COLOR_RED + COLOR_W'(best_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            color4_reg <= color_next;
            glyph4_reg <= glyph_char(level3_reg);
        end
    end

    assign m_tdata = {3'b000, color4_reg, glyph4_reg};

endmodule
